/* rtl/smsc_pkg.sv */
// Shared widths, register map and defaults for the sorted mean screen.
`default_nettype none
package smsc_pkg;

	localparam int MAX_GROUPS     = 4;
	localparam int GROUPS_DEFAULT = 4;

	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 16;
	localparam int LAMBDA_W = 32;
	// scaled sample: signed 32 x unsigned 16 stays within 48 signed bits
	localparam int PROD_W   = 48;
	// sum of up to four scaled samples
	localparam int SUM_W    = 50;
	// r * (lambda_sparsity + (groups - r) * lambda_fusion), r up to four
	localparam int BOUND_W  = 36;

	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_LAMBDA_SPARSITY = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LAMBDA_FUSION   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_GROUP0    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_GROUP1    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_GROUP2    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_GROUP3    = 3'd5;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1;

endpackage
`default_nettype wire

/* rtl/smsc_lane.sv */
// One scaling lane: multiplies a group's sample by its sample count.
`default_nettype none
module smsc_lane (
	input  wire                                   clk,
	input  wire                                   en,
	input  wire signed [smsc_pkg::SAMPLE_W-1:0]   sample,
	input  wire        [smsc_pkg::COUNT_W-1:0]    count,
	output logic signed [smsc_pkg::PROD_W-1:0]    prod_s1
);
	import smsc_pkg::*;

	logic signed [SAMPLE_W+COUNT_W:0] full;

	assign full = sample * $signed({1'b0, count});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= full[PROD_W-1:0];
		end
	end

endmodule
`default_nettype wire

/* rtl/smsc_sort.sv */
// Rank sort of the scaled lane values, ascending, ties kept in lane order.
`default_nettype none
module smsc_sort #(
	parameter int GROUPS = smsc_pkg::GROUPS_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire signed [smsc_pkg::PROD_W-1:0]    vals [GROUPS],
	output logic signed [smsc_pkg::PROD_W-1:0]   sorted_s2 [GROUPS]
);
	import smsc_pkg::*;

	localparam int RANK_W = $clog2(GROUPS);

	logic        [RANK_W-1:0] rank  [GROUPS];
	logic signed [PROD_W-1:0] placed [GROUPS];

	// rank = number of lanes that come before this one in sorted order
	always_comb begin
		for (int i = 0; i < GROUPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < GROUPS; j++) begin
				if (j != i) begin
					if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
						rank[i] = rank[i] + RANK_W'(1);
					end
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < GROUPS; k++) begin
			placed[k] = '0;
			for (int i = 0; i < GROUPS; i++) begin
				if (rank[i] == RANK_W'(k)) begin
					placed[k] = vals[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sorted_s2 <= placed;
		end
	end

endmodule
`default_nettype wire

/* rtl/smsc_merge.sv */
// Merge stage: run sums from both ends of the sorted list and bound compare.
`default_nettype none
module smsc_merge #(
	parameter int GROUPS = smsc_pkg::GROUPS_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire signed [smsc_pkg::PROD_W-1:0]    sorted [GROUPS],
	input  wire        [smsc_pkg::BOUND_W-1:0]   bound [GROUPS],
	output logic                                 hit_next
);
	import smsc_pkg::*;

	logic signed [SUM_W-1:0] lo_sum [GROUPS];
	logic signed [SUM_W-1:0] hi_sum [GROUPS];
	logic signed [SUM_W-1:0] lo_s3  [GROUPS];
	logic signed [SUM_W-1:0] hi_s3  [GROUPS];
	logic        [SUM_W-1:0] lo_mag [GROUPS];
	logic        [SUM_W-1:0] hi_mag [GROUPS];

	always_comb begin
		lo_sum[0] = SUM_W'(sorted[0]);
		hi_sum[0] = SUM_W'(sorted[GROUPS-1]);
		for (int r = 1; r < GROUPS; r++) begin
			lo_sum[r] = lo_sum[r-1] + SUM_W'(sorted[r]);
			hi_sum[r] = hi_sum[r-1] + SUM_W'(sorted[GROUPS-1-r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= lo_sum;
			hi_s3 <= hi_sum;
		end
	end

	// equality with the bound does not hit
	always_comb begin
		hit_next = 1'b0;
		for (int r = 0; r < GROUPS; r++) begin
			lo_mag[r] = lo_s3[r][SUM_W-1] ? SUM_W'(-lo_s3[r]) : SUM_W'(lo_s3[r]);
			hi_mag[r] = hi_s3[r][SUM_W-1] ? SUM_W'(-hi_s3[r]) : SUM_W'(hi_s3[r]);
			if ((lo_mag[r] > SUM_W'(bound[r])) || (hi_mag[r] > SUM_W'(bound[r]))) begin
				hit_next = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/sorted_mean_screen.sv */
// Top level of the sorted mean screen: register file, lanes, sort, merge, output.
// Registered stages from a sample transfer to the hit transfer:
// scale, sort, run sums, then compare into the output register.
// Throughput: one item per cycle while hit_stall is low; every stage advances
// independently so a bubble closes up even while hit_valid is stalled.
// Reset: clears all stage valids, sets both lambdas to 0 and every count to 1.
`default_nettype none
module sorted_mean_screen #(
	parameter int GROUPS = smsc_pkg::GROUPS_DEFAULT
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [smsc_pkg::ADDR_W-1:0]           paddr,
	input  wire  [smsc_pkg::DATA_W-1:0]           pwdata,
	output logic [smsc_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready,
	input  wire                                   sample_valid,
	output logic                                  sample_stall,
	input  wire  signed [smsc_pkg::SAMPLE_W-1:0]  sample_group0,
	input  wire  signed [smsc_pkg::SAMPLE_W-1:0]  sample_group1,
	input  wire  signed [smsc_pkg::SAMPLE_W-1:0]  sample_group2,
	input  wire  signed [smsc_pkg::SAMPLE_W-1:0]  sample_group3,
	output logic                                  hit_valid,
	input  wire                                   hit_stall,
	output logic                                  hit
);
	import smsc_pkg::*;

	logic [LAMBDA_W-1:0]      lambda_sparsity_q;
	logic [LAMBDA_W-1:0]      lambda_fusion_q;
	logic [COUNT_W-1:0]       count_q [MAX_GROUPS];
	logic [BOUND_W-1:0]       bound_q [GROUPS];
	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     wr_en;

	logic signed [SAMPLE_W-1:0] samples [MAX_GROUPS];
	logic signed [PROD_W-1:0]   prod_s1 [GROUPS];
	logic signed [PROD_W-1:0]   sorted_s2 [GROUPS];

	logic valid_s1, valid_s2, valid_s3, out_valid_q, hit_q;
	logic en_s1, en_s2, en_s3, en_out;
	logic hit_next;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_sparsity_q <= '0;
			lambda_fusion_q   <= '0;
			for (int g = 0; g < MAX_GROUPS; g++) begin
				count_q[g] <= COUNT_RESET;
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LAMBDA_SPARSITY: lambda_sparsity_q <= pwdata[LAMBDA_W-1:0];
				REG_LAMBDA_FUSION:   lambda_fusion_q   <= pwdata[LAMBDA_W-1:0];
				REG_COUNT_GROUP0:    count_q[0]        <= pwdata[COUNT_W-1:0];
				REG_COUNT_GROUP1:    count_q[1]        <= pwdata[COUNT_W-1:0];
				REG_COUNT_GROUP2:    count_q[2]        <= pwdata[COUNT_W-1:0];
				REG_COUNT_GROUP3:    count_q[3]        <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LAMBDA_SPARSITY: prdata = DATA_W'(lambda_sparsity_q);
			REG_LAMBDA_FUSION:   prdata = DATA_W'(lambda_fusion_q);
			REG_COUNT_GROUP0:    prdata = DATA_W'(count_q[0]);
			REG_COUNT_GROUP1:    prdata = DATA_W'(count_q[1]);
			REG_COUNT_GROUP2:    prdata = DATA_W'(count_q[2]);
			REG_COUNT_GROUP3:    prdata = DATA_W'(count_q[3]);
			default:             prdata = '0;
		endcase
	end

	// run-length bounds are computed from the lambda registers and registered
	always_ff @(posedge clk) begin
		for (int r = 0; r < GROUPS; r++) begin
			bound_q[r] <= BOUND_W'(r + 1) * (BOUND_W'(lambda_sparsity_q)
				+ BOUND_W'(GROUPS - 1 - r) * BOUND_W'(lambda_fusion_q));
		end
	end

	// a stage advances when it is empty or the next one advances
	assign en_out       = !out_valid_q || !hit_stall;
	assign en_s3        = !valid_s3 || en_out;
	assign en_s2        = !valid_s2 || en_s3;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  valid_s1    <= sample_valid;
			if (en_s2)  valid_s2    <= valid_s1;
			if (en_s3)  valid_s3    <= valid_s2;
			if (en_out) out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			hit_q <= hit_next;
		end
	end

	assign hit_valid = out_valid_q;
	assign hit       = hit_q;

	assign samples[0] = sample_group0;
	assign samples[1] = sample_group1;
	assign samples[2] = sample_group2;
	assign samples[3] = sample_group3;

	for (genvar g = 0; g < GROUPS; g++) begin : g_lane
		smsc_lane u_lane (
			.clk     (clk),
			.en      (en_s1),
			.sample  (samples[g]),
			.count   (count_q[g]),
			.prod_s1 (prod_s1[g])
		);
	end

	smsc_sort #(.GROUPS(GROUPS)) u_sort (
		.clk       (clk),
		.en        (en_s2),
		.vals      (prod_s1),
		.sorted_s2 (sorted_s2)
	);

	smsc_merge #(.GROUPS(GROUPS)) u_merge (
		.clk      (clk),
		.en       (en_s3),
		.sorted   (sorted_s2),
		.bound    (bound_q),
		.hit_next (hit_next)
	);

endmodule
`default_nettype wire

/* rtl/smsc_check.sv */
// Port-level checker for the sorted mean screen, bound to the top level.
`default_nettype none
module smsc_check (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  sample_valid,
	input wire                                  sample_stall,
	input wire signed [smsc_pkg::SAMPLE_W-1:0]  sample_group0,
	input wire signed [smsc_pkg::SAMPLE_W-1:0]  sample_group1,
	input wire signed [smsc_pkg::SAMPLE_W-1:0]  sample_group2,
	input wire signed [smsc_pkg::SAMPLE_W-1:0]  sample_group3,
	input wire                                  hit_valid,
	input wire                                  hit_stall,
	input wire                                  hit
);
	import smsc_pkg::*;

	logic accept;
	logic all_zero;

	assign accept   = sample_valid && !sample_stall;
	assign all_zero = (sample_group0 == '0) && (sample_group1 == '0)
		&& (sample_group2 == '0) && (sample_group3 == '0);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_stall |=> hit_valid && $stable(hit))
		else $error("stalled hit transfer changed");

	// an empty output never pushes back on the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!hit_valid |-> !sample_stall)
		else $error("input stalled while output empty");

	// with the output free throughout, an accepted transfer shows up as hit_valid
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !hit_stall ##1 !hit_stall ##1 !hit_stall ##1 !hit_stall)
		|=> hit_valid)
		else $error("hit missing after unstalled transfer");

	// all-zero samples can never pass a bound
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && all_zero && !hit_stall ##1 !hit_stall ##1 !hit_stall
		##1 !hit_stall) |=> !hit)
		else $error("hit raised for zero samples");

endmodule

bind sorted_mean_screen smsc_check u_smsc_check (.*);
`default_nettype wire
